### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the path scatter restager
// Item layouts, per-path table entry and register/action codes.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int IDX_W     = 24;  // slot, run count and rank counter width
  localparam int RANK_W    = 25;  // stored last rank (sentinel may carry)
  localparam int PATH_W    = 7;
  localparam int PAY_W     = 31;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_DISCRETE = 2'd0;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_RESTAGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_RANK_START = 2'd1,
    CFG_CELL_RUNS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              action;
    logic [PATH_W-1:0] path;
    logic              path_active;
    logic              first_of_cell;
    logic [PAY_W-1:0]  obs_payload;
    logic              obs_tied;
    logic [IDX_W-1:0]  sample_index;
    logic [IDX_W-1:0]  obs_base;
    logic [IDX_W-1:0]  val_base;
    logic [IDX_W-1:0]  run_count_init;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  obs_dest;
    logic [PAY_W-1:0]  out_payload;
    logic              out_tied;
    logic [IDX_W-1:0]  out_sample_index;
    logic [PATH_W-1:0] out_path;
    logic              val_write;
    logic [IDX_W-1:0]  val_dest;
    logic [IDX_W-1:0]  val_src_index;
    logic [IDX_W-1:0]  run_count;
  } out_item_t;

  // Per-path slot table entry
  typedef struct packed {
    logic [IDX_W-1:0] obs_slot;
    logic [IDX_W-1:0] val_slot;
    logic [IDX_W-1:0] runs;
  } slot_entry_t;

endpackage

### rtl/pst_stream_if.sv
// ----------------------------------------------------------------------------
// pst_stream_if: valid/ready stream channel
// Carries one word of type payload_t per handshake.
// ----------------------------------------------------------------------------
interface pst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/path_scatter_restager.sv
// ----------------------------------------------------------------------------
// path_scatter_restager: stable scatter of sorted observations into paths
// Active, in-range restage words pass the compute stage, then the output register.
// Throughput: one word per cycle while res_out does not stall; the per-path
//   read-modify-write is a registered read, then compute/write-back, with forwarding.
// Reset: registers, rank counter and valid flags clear; table contents stay
//   undefined until written; slot entries take their bases from a load word.
// ----------------------------------------------------------------------------
module path_scatter_restager #(
  parameter int NUM_PATHS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pst_pkg::IDX_W-1:0]     cfg_data,
  pst_stream_if.sink                    obs_in,
  pst_stream_if.source                  res_out
);
  import pst_pkg::*;

  localparam int PATH_AW = $clog2(NUM_PATHS);

  // Configuration registers
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  rank_start;
  logic [IDX_W-1:0]  cell_run_count;

  // Cell-wide rank state
  logic [IDX_W-1:0]  rank_counter;
  logic [RANK_W-1:0] sentinel;      // last rank of a path not hit since cell start
  logic [NUM_PATHS-1:0] written;    // last_rank entry written since cell start
  logic [NUM_PATHS-1:0] written_next;

  // Compute stage (word whose table read is in flight)
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_fire;
  logic     s1_has_out;

  // Output register
  logic      res_valid;
  out_item_t res_item;
  out_item_t res_next;
  logic      out_free;
  logic      in_ready;
  logic      in_accept;

  // Table ports
  logic [PATH_AW-1:0] s1_addr;
  slot_entry_t        slot_rd;
  logic [RANK_W-1:0]  rank_rd;
  logic               slot_we;
  logic               rank_we;
  slot_entry_t        slot_wr;
  logic [RANK_W-1:0]  rank_wr;

  // Per-word decode
  logic              is_restage;
  logic              path_ok;
  logic              track;
  logic              values;
  logic              first;
  logic              tied_src;
  logic [IDX_W-1:0]  rc_base;
  logic [IDX_W-1:0]  rc_now;
  logic [RANK_W-1:0] sent_now;
  logic [RANK_W-1:0] prev_rank;
  logic              new_run;

  // --------------------------------------------------------------------------
  // Configuration writes; an index past the register list is dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= '0;
      rank_start     <= '0;
      cell_run_count <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MODE:       mode           <= cfg_data[MODE_W-1:0];
        CFG_RANK_START: rank_start     <= cfg_data;
        CFG_CELL_RUNS:  cell_run_count <= cfg_data;
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the compute stage advances unless it owes a word to a full,
  // stalled output register; a new word enters whenever the stage moves on.
  // --------------------------------------------------------------------------
  assign out_free   = !res_valid || res_out.ready;
  assign s1_fire    = s1_valid && (!s1_has_out || out_free);
  assign in_ready   = !s1_valid || s1_fire;
  assign in_accept  = obs_in.valid && in_ready;
  assign obs_in.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= obs_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= obs_in.data;
    end
  end

  // --------------------------------------------------------------------------
  // Per-path tables: read at accept, write back when the stage fires
  // --------------------------------------------------------------------------
  assign s1_addr = PATH_AW'(s1_item.path);

  pst_path_table #(
    .NUM_PATHS (NUM_PATHS),
    .PATH_AW   (PATH_AW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_accept),
    .rd_addr    (PATH_AW'(obs_in.data.path)),
    .slot_we    (slot_we),
    .rank_we    (rank_we),
    .wr_addr    (s1_addr),
    .slot_wdata (slot_wr),
    .rank_wdata (rank_wr),
    .slot_rdata (slot_rd),
    .rank_rdata (rank_rd)
  );

  // --------------------------------------------------------------------------
  // Rank tracking and run detection
  // --------------------------------------------------------------------------
  assign is_restage = (s1_item.action == ACT_RESTAGE);
  assign path_ok    = 32'(s1_item.path) < NUM_PATHS;
  assign track      = (mode != MODE_DISCRETE);
  assign values     = mode[1];            // mode three behaves as values mode
  assign first      = s1_item.first_of_cell;
  assign tied_src   = s1_item.obs_tied || first;

  // Restart the counter and the sentinel on a cell's first word
  assign rc_base  = first ? (values ? rank_start : '0) : rank_counter;
  assign rc_now   = tied_src ? rc_base : rc_base + 1'b1;
  assign sent_now = first
    ? ((values ? RANK_W'(rank_start) : '0) + RANK_W'(cell_run_count))
    : sentinel;

  // An entry not touched since cell start holds the sentinel
  always_comb begin
    if (first || !written[s1_addr]) begin
      prev_rank = sent_now;
    end else begin
      prev_rank = rank_rd;
    end
  end

  assign new_run    = (RANK_W'(rc_now) != prev_rank);
  assign s1_has_out = is_restage && s1_item.path_active && path_ok;

  // --------------------------------------------------------------------------
  // Write-back and result assembly
  // --------------------------------------------------------------------------
  always_comb begin
    slot_we  = 1'b0;
    rank_we  = 1'b0;
    slot_wr  = slot_rd;
    rank_wr  = RANK_W'(rc_now);
    res_next = '0;

    res_next.obs_dest         = slot_rd.obs_slot;
    res_next.out_payload      = s1_item.obs_payload;
    res_next.out_tied         = tied_src;
    res_next.out_sample_index = s1_item.sample_index;
    res_next.out_path         = s1_item.path;

    if (s1_fire) begin
      if (!is_restage) begin
        // Load path bases
        slot_we          = path_ok;
        slot_wr.obs_slot = s1_item.obs_base;
        slot_wr.val_slot = s1_item.val_base;
        slot_wr.runs     = s1_item.run_count_init;
      end else if (s1_has_out) begin
        slot_we          = 1'b1;
        slot_wr.obs_slot = slot_rd.obs_slot + 1'b1;
        if (track) begin
          res_next.out_tied = !new_run;
          if (new_run) begin
            rank_we      = 1'b1;
            slot_wr.runs = slot_rd.runs + 1'b1;
            if (values) begin
              slot_wr.val_slot       = slot_rd.val_slot + 1'b1;
              res_next.val_write     = 1'b1;
              res_next.val_dest      = slot_rd.val_slot;
              res_next.val_src_index = rc_now;
            end
          end
        end
      end
    end
    res_next.run_count = slot_wr.runs;
  end

  // Drop all written flags at cell start, then mark the path just updated
  always_comb begin
    written_next = (s1_fire && is_restage && first) ? '0 : written;
    if (rank_we) begin
      written_next[s1_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_counter <= '0;
      sentinel     <= '0;
      written      <= '0;
    end else begin
      written <= written_next;
      if (s1_fire && is_restage) begin
        rank_counter <= rc_now;
        sentinel     <= sent_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold until taken, refill from the stage when it fires
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_has_out) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_out) begin
      res_item <= res_next;
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.data  = res_item;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> (res_valid && !res_out.ready))
    else $error("compute stage stalled with a free output register");

  a_rank_write_with_slot_write: assert property (@(posedge clk) disable iff (rst)
    rank_we |-> (slot_we && s1_fire && is_restage))
    else $error("last rank written without a slot write-back");

  a_no_value_fields_without_copy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.val_write) |->
      (res_item.val_dest == '0 && res_item.val_src_index == '0))
    else $error("value fields set without a value copy");

  a_cell_start_clears_flags: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && is_restage && first) |=> ($countones(written) <= 1))
    else $error("written flags survived a cell start");

  a_discrete_no_value_copy: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_has_out && !values) |=> !res_item.val_write)
    else $error("value copy requested outside values mode");

endmodule

### rtl/pst_path_table.sv
// ----------------------------------------------------------------------------
// pst_path_table: per-path slot and last-rank memories
// Registered read; a write that lands on the read edge is forwarded.
// ----------------------------------------------------------------------------
module pst_path_table #(
  parameter int NUM_PATHS = 128,
  parameter int PATH_AW   = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [PATH_AW-1:0]         rd_addr,
  input  logic                       slot_we,
  input  logic                       rank_we,
  input  logic [PATH_AW-1:0]         wr_addr,
  input  pst_pkg::slot_entry_t       slot_wdata,
  input  logic [pst_pkg::RANK_W-1:0] rank_wdata,
  output pst_pkg::slot_entry_t       slot_rdata,
  output logic [pst_pkg::RANK_W-1:0] rank_rdata
);
  import pst_pkg::*;

  slot_entry_t       slot_mem [NUM_PATHS];
  logic [RANK_W-1:0] rank_mem [NUM_PATHS];

  slot_entry_t       slot_q;
  logic [RANK_W-1:0] rank_q;
  slot_entry_t       slot_fwd;
  logic [RANK_W-1:0] rank_fwd;
  logic              slot_hit;
  logic              rank_hit;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[wr_addr] <= slot_wdata;
    end
    if (rank_we) begin
      rank_mem[wr_addr] <= rank_wdata;
    end
    if (rd_en) begin
      slot_q   <= slot_mem[rd_addr];
      rank_q   <= rank_mem[rd_addr];
      slot_fwd <= slot_wdata;
      rank_fwd <= rank_wdata;
    end
  end

  // Track whether the read raced a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_hit <= 1'b0;
      rank_hit <= 1'b0;
    end else if (rd_en) begin
      slot_hit <= slot_we && (wr_addr == rd_addr);
      rank_hit <= rank_we && (wr_addr == rd_addr);
    end
  end

  assign slot_rdata = slot_hit ? slot_fwd : slot_q;
  assign rank_rdata = rank_hit ? rank_fwd : rank_q;

endmodule
